// ===== src/rict_pkg.sv =====
// ----------------------------------------------------------------------------
// rict_pkg: shared types and constants of the reference-counted cache table
// Operation and status codes, default sizes, and the structs that travel
// between the controller and the row of entry cells.
// ----------------------------------------------------------------------------
package rict_pkg;

  localparam int ENTRIES_DEF    = 64;
  localparam int COUNT_BITS_DEF = 16;

  // Widest index and count over the whole parameter range.
  localparam int IDX_MAX_W = 10;
  localparam int CNT_MAX_W = 32;

  typedef enum logic [2:0] {
    OP_ACQUIRE    = 3'd0,
    OP_PIN        = 3'd1,
    OP_RELEASE    = 3'd2,
    OP_MARK_VALID = 3'd3,
    OP_MOUNT      = 3'd4,
    OP_UNMOUNT    = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    STAT_OK          = 3'd0,
    STAT_FULL        = 3'd1,
    STAT_RELEASED    = 3'd2,
    STAT_NOT_VALID   = 3'd3,
    STAT_NOT_DIR     = 3'd4,
    STAT_NOT_MOUNTED = 3'd5,
    STAT_OVERFLOW    = 3'd6
  } stat_t;

  typedef struct packed {
    logic                 acquire;
    logic [IDX_MAX_W-1:0] slot_idx;
    logic [15:0]          volume_id;
    logic [31:0]          file_id;
  } probe_t;

  typedef struct packed {
    logic                 active;
    logic                 sel_found;
    logic [IDX_MAX_W-1:0] sel_idx;
    logic [CNT_MAX_W-1:0] sel_count;
    logic                 sel_valid;
    logic                 sel_mount;
    logic                 free_found;
    logic [IDX_MAX_W-1:0] free_idx;
  } scan_t;

  typedef struct packed {
    logic                 en;
    logic [IDX_MAX_W-1:0] idx;
    logic                 alloc;
    logic [15:0]          volume_id;
    logic [31:0]          file_id;
    logic                 count_en;
    logic [CNT_MAX_W-1:0] count;
    logic                 valid_en;
    logic                 valid;
    logic                 mount_en;
    logic                 mount;
  } write_t;

endpackage

// ===== src/rict_req_if.sv =====
// ----------------------------------------------------------------------------
// rict_req_if: request channel of the cache table
// Valid/ready channel that carries one operation per transaction.
// ----------------------------------------------------------------------------
interface rict_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [15:0] volume_id;
  logic [31:0] file_id;
  logic [5:0]  slot;
  logic        is_directory;

  modport source (
    output valid, operation, volume_id, file_id, slot, is_directory,
    input  ready
  );
  modport sink (
    input  valid, operation, volume_id, file_id, slot, is_directory,
    output ready
  );
endinterface

// ===== src/rict_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rict_rsp_if: response channel of the cache table
// Valid/ready channel that carries one result per transaction.
// ----------------------------------------------------------------------------
interface rict_rsp_if;
  logic        valid;
  logic        ready;
  logic [5:0]  result_slot;
  logic        hit;
  logic [2:0]  status;
  logic [15:0] count_after;
  logic        became_free;
  logic        mounted;
  logic        entry_valid;

  modport source (
    output valid, result_slot, hit, status, count_after, became_free, mounted,
           entry_valid,
    input  ready
  );
  modport sink (
    input  valid, result_slot, hit, status, count_after, became_free, mounted,
           entry_valid,
    output ready
  );
endinterface

// ===== src/refcounted_inode_cache_table.sv =====
// ----------------------------------------------------------------------------
// refcounted_inode_cache_table: reference-counted object cache table
// A row of entry cells with a small controller that scans and then commits.
// ----------------------------------------------------------------------------
// The req channel takes one operation per transaction: acquire, pin, release,
// mark valid, mount or unmount. The rsp channel returns exactly one result per
// request, in order. Each accepted request starts a scan record that walks the
// row of ENTRIES cells, one cell per cycle, collecting the first matching or
// addressed entry and the first free entry. When the record leaves the last
// cell the controller decides the result, writes the chosen entry and loads
// the response register in the same cycle.
// A request passes the launch register, the cell registers and the summary
// register before its commit; a new request is accepted only after that commit,
// so the walk along the row sets the pace of the table.
// A new request may be accepted while an earlier result still waits on rsp.
// If the receiver stalls, the commit waits until the response register frees,
// and the table is not changed before then. Reset (rst, synchronous) empties
// every entry and drops any request or result in flight.
// ----------------------------------------------------------------------------
module refcounted_inode_cache_table #(
  parameter int ENTRIES    = rict_pkg::ENTRIES_DEF,
  parameter int COUNT_BITS = rict_pkg::COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  rict_req_if.sink   req,
  rict_rsp_if.source rsp
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_COMMIT = 3'b100
  } state_t;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  state_t                state;
  state_t                state_next;
  logic                  launch;
  logic [2:0]            op_q;
  logic [15:0]           volume_q;
  logic [31:0]           file_q;
  logic [5:0]            slot_q;
  logic                  dir_q;
  rict_pkg::probe_t      probe;
  rict_pkg::scan_t       chain [0:ENTRIES];
  rict_pkg::scan_t       summ;
  rict_pkg::write_t      wr;
  logic                  req_acc;
  logic                  commit;
  logic                  rsp_valid;
  logic [5:0]            rsp_slot;
  logic                  rsp_hit;
  logic [2:0]            rsp_status;
  logic [15:0]           rsp_count;
  logic                  rsp_free;
  logic                  rsp_mount;
  logic                  rsp_ev;
  logic [5:0]            res_slot;
  logic                  res_hit;
  rict_pkg::stat_t       res_status;
  logic [COUNT_BITS-1:0] res_count;
  logic                  res_free;
  logic                  res_mount;
  logic                  res_ev;
  logic [COUNT_BITS-1:0] cnt;
  logic                  in_range;

  assign req.ready = (state == ST_IDLE);
  assign req_acc   = req.valid && req.ready;
  assign commit    = (state == ST_COMMIT) && (!rsp_valid || rsp.ready);

  assign probe.acquire   = (op_q == rict_pkg::OP_ACQUIRE);
  assign probe.slot_idx  = rict_pkg::IDX_MAX_W'(slot_q);
  assign probe.volume_id = volume_q;
  assign probe.file_id   = file_q;

  always_comb begin
    chain[0]        = '0;
    chain[0].active = launch;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    rict_cell #(
      .INDEX      (i),
      .COUNT_BITS (COUNT_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .probe    (probe),
      .wr       (wr),
      .scan_in  (chain[i]),
      .scan_out (chain[i+1])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_acc) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (chain[ENTRIES].active) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (commit) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      launch <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= req_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc) begin
      op_q     <= req.operation;
      volume_q <= req.volume_id;
      file_q   <= req.file_id;
      slot_q   <= req.slot;
      dir_q    <= req.is_directory;
    end
    if (state == ST_SCAN && chain[ENTRIES].active) begin
      summ <= chain[ENTRIES];
    end
  end

  assign cnt      = summ.sel_count[COUNT_BITS-1:0];
  assign in_range = (32'(slot_q) < 32'(ENTRIES));

  always_comb begin
    res_slot   = '0;
    res_hit    = 1'b0;
    res_status = rict_pkg::STAT_OK;
    res_count  = '0;
    res_free   = 1'b0;
    res_mount  = 1'b0;
    res_ev     = 1'b0;
    wr           = '0;
    wr.volume_id = volume_q;
    wr.file_id   = file_q;
    unique case (rict_pkg::op_t'(op_q))
      rict_pkg::OP_ACQUIRE: begin
        if (summ.sel_found) begin
          res_slot  = 6'(summ.sel_idx);
          res_hit   = 1'b1;
          res_mount = summ.sel_mount;
          res_ev    = summ.sel_valid;
          if (cnt == CNT_MAX) begin
            res_status = rict_pkg::STAT_OVERFLOW;
            res_count  = cnt;
          end else begin
            res_count   = cnt + 1'b1;
            wr.en       = 1'b1;
            wr.idx      = summ.sel_idx;
            wr.count_en = 1'b1;
            wr.count    = rict_pkg::CNT_MAX_W'(res_count);
          end
        end else if (summ.free_found) begin
          res_slot    = 6'(summ.free_idx);
          res_count   = COUNT_BITS'(1);
          wr.en       = 1'b1;
          wr.idx      = summ.free_idx;
          wr.alloc    = 1'b1;
          wr.count_en = 1'b1;
          wr.count    = rict_pkg::CNT_MAX_W'(1);
          wr.valid_en = 1'b1;
          wr.mount_en = 1'b1;
        end else begin
          res_status = rict_pkg::STAT_FULL;
        end
      end
      rict_pkg::OP_PIN, rict_pkg::OP_RELEASE, rict_pkg::OP_MARK_VALID,
      rict_pkg::OP_MOUNT, rict_pkg::OP_UNMOUNT: begin
        res_slot = slot_q;
        if (!in_range) begin
          res_status = rict_pkg::STAT_NOT_VALID;
        end else begin
          res_count = cnt;
          res_mount = summ.sel_mount;
          res_ev    = summ.sel_valid;
          wr.idx    = summ.sel_idx;
          unique case (rict_pkg::op_t'(op_q))
            rict_pkg::OP_PIN: begin
              if (cnt == '0) begin
                res_status = rict_pkg::STAT_RELEASED;
              end else if (cnt == CNT_MAX) begin
                res_status = rict_pkg::STAT_OVERFLOW;
              end else begin
                res_count   = cnt + 1'b1;
                wr.en       = 1'b1;
                wr.count_en = 1'b1;
              end
            end
            rict_pkg::OP_RELEASE: begin
              if (cnt == '0) begin
                res_status = rict_pkg::STAT_RELEASED;
              end else begin
                res_count   = cnt - 1'b1;
                res_free    = (cnt == COUNT_BITS'(1));
                wr.en       = 1'b1;
                wr.count_en = 1'b1;
              end
            end
            rict_pkg::OP_MARK_VALID: begin
              if (cnt == '0) begin
                res_status = rict_pkg::STAT_RELEASED;
              end else begin
                res_ev      = 1'b1;
                wr.en       = 1'b1;
                wr.valid_en = 1'b1;
                wr.valid    = 1'b1;
              end
            end
            rict_pkg::OP_MOUNT: begin
              if (!dir_q) begin
                res_status = rict_pkg::STAT_NOT_DIR;
              end else if (!summ.sel_valid) begin
                res_status = rict_pkg::STAT_NOT_VALID;
              end else begin
                res_mount   = 1'b1;
                wr.en       = 1'b1;
                wr.mount_en = 1'b1;
                wr.mount    = 1'b1;
              end
            end
            default: begin
              if (!dir_q) begin
                res_status = rict_pkg::STAT_NOT_DIR;
              end else if (!summ.sel_valid) begin
                res_status = rict_pkg::STAT_NOT_VALID;
              end else if (!summ.sel_mount) begin
                res_status = rict_pkg::STAT_NOT_MOUNTED;
              end else begin
                res_mount   = 1'b0;
                wr.en       = 1'b1;
                wr.mount_en = 1'b1;
                wr.mount    = 1'b0;
              end
            end
          endcase
          wr.count = rict_pkg::CNT_MAX_W'(res_count);
        end
      end
      default: begin
      end
    endcase
    wr.en = wr.en && commit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp_slot   <= res_slot;
      rsp_hit    <= res_hit;
      rsp_status <= res_status;
      rsp_count  <= 16'(res_count);
      rsp_free   <= res_free;
      rsp_mount  <= res_mount;
      rsp_ev     <= res_ev;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.result_slot = rsp_slot;
  assign rsp.hit         = rsp_hit;
  assign rsp.status      = rsp_status;
  assign rsp.count_after = rsp_count;
  assign rsp.became_free = rsp_free;
  assign rsp.mounted     = rsp_mount;
  assign rsp.entry_valid = rsp_ev;

`ifndef SYNTHESIS
  a_idle_no_scan: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !chain[ENTRIES].active)
    else $error("Scan record reached the row end while the controller was idle.");

  a_rsp_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == ST_COMMIT))
    else $error("Response became valid without a commit.");

  a_free_is_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_free |-> rsp_status == rict_pkg::STAT_OK && rsp_count == '0)
    else $error("Entry reported free with a nonzero count or an error status.");
`endif

endmodule

// ===== src/rict_cell.sv =====
// ----------------------------------------------------------------------------
// rict_cell: one entry of the cache table
// Holds one entry, checks the scan record passing by against it and hands the
// record to the next cell, and takes its share of the commit write.
// ----------------------------------------------------------------------------
module rict_cell #(
  parameter int INDEX      = 0,
  parameter int COUNT_BITS = rict_pkg::COUNT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  rict_pkg::probe_t probe,
  input  rict_pkg::write_t wr,
  input  rict_pkg::scan_t  scan_in,
  output rict_pkg::scan_t  scan_out
);

  localparam logic [rict_pkg::IDX_MAX_W-1:0] MY_IDX = rict_pkg::IDX_MAX_W'(INDEX);

  logic                  occupied;
  logic                  valid;
  logic                  mount;
  logic [15:0]           volume;
  logic [31:0]           file;
  logic [COUNT_BITS-1:0] count;
  logic                  own;
  logic                  match;
  logic                  is_free;
  rict_pkg::scan_t       scan_next;

  assign own     = wr.en && (wr.idx == MY_IDX);
  assign is_free = (count == '0) && !mount;
  assign match   = probe.acquire
                 ? (occupied && volume == probe.volume_id && file == probe.file_id)
                 : (probe.slot_idx == MY_IDX);

  always_comb begin
    scan_next = scan_in;
    if (!scan_in.sel_found && match) begin
      scan_next.sel_found = 1'b1;
      scan_next.sel_idx   = MY_IDX;
      scan_next.sel_count = rict_pkg::CNT_MAX_W'(count);
      scan_next.sel_valid = valid;
      scan_next.sel_mount = mount;
    end
    if (!scan_in.free_found && is_free) begin
      scan_next.free_found = 1'b1;
      scan_next.free_idx   = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= 1'b0;
      valid    <= 1'b0;
      mount    <= 1'b0;
      count    <= '0;
    end else if (own) begin
      if (wr.alloc) begin
        occupied <= 1'b1;
      end
      if (wr.count_en) begin
        count <= wr.count[COUNT_BITS-1:0];
      end
      if (wr.valid_en) begin
        valid <= wr.valid;
      end
      if (wr.mount_en) begin
        mount <= wr.mount;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (own && wr.alloc) begin
      volume <= wr.volume_id;
      file   <= wr.file_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out.active <= 1'b0;
    end else begin
      scan_out <= scan_next;
    end
  end

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking testbench for refcounted_inode_cache_table
// A queue of table operations feeds a clocked driver. Each accepted
// transaction is applied to a local copy of the table, and the expected
// result is queued. A clocked monitor compares every response field with
// the oldest expected result. The stimulus opens with directed operations
// and continues with random segments that mix, fill and drain the table.
// Both sides stall at random, and there is one long response hold-off.
// ----------------------------------------------------------------------------
module tb;

  localparam int          ENTRIES   = rict_pkg::ENTRIES_DEF;
  localparam logic [15:0] COUNT_MAX = 16'((64'd1 << rict_pkg::COUNT_BITS_DEF) - 1);
  localparam logic [2:0]  OP_RESERVED_LO = 3'd6;
  localparam logic [2:0]  OP_RESERVED_HI = 3'd7;
  localparam int          RANDOM_CMDS    = 850;

  typedef enum int {SEG_MIXED, SEG_FILL, SEG_DRAIN} seg_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] volume_id;
    logic [31:0] file_id;
    logic [5:0]  slot;
    logic        is_directory;
    logic        hold_until_idle;
  } table_cmd_t;

  typedef struct packed {
    logic [5:0]      result_slot;
    logic            hit;
    rict_pkg::stat_t status;
    logic [15:0]     count_after;
    logic            became_free;
    logic            mounted;
    logic            entry_valid;
  } table_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rict_req_if req_ch ();
  rict_rsp_if rsp_ch ();

  refcounted_inode_cache_table i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #2 clk = ~clk;

  table_cmd_t  pending_cmds[$];
  table_rsp_t  expected_results[$];
  logic [47:0] known_ids[$];
  table_cmd_t  on_offer;
  int unsigned cycle_no = 0;
  int unsigned accepted_count = 0;
  int unsigned mismatches = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  logic        occupied_tbl [ENTRIES] = '{default: 1'b0};
  logic [15:0] vol_tbl      [ENTRIES] = '{default: '0};
  logic [31:0] file_tbl     [ENTRIES] = '{default: '0};
  logic [15:0] count_tbl    [ENTRIES] = '{default: '0};
  logic        valid_tbl    [ENTRIES] = '{default: 1'b0};
  logic        mount_tbl    [ENTRIES] = '{default: 1'b0};

  function automatic table_rsp_t apply_to_table(table_cmd_t c);
    table_rsp_t r;
    int         i;
    int         hit_at;
    int         free_at;
    int         s;
    logic       freed;
    r       = '0;
    hit_at  = -1;
    free_at = -1;
    freed   = 1'b0;
    s       = c.slot;
    if (c.operation == rict_pkg::OP_ACQUIRE) begin
      for (i = 0; i < ENTRIES; i++) begin
        if (hit_at < 0 && occupied_tbl[i] && vol_tbl[i] == c.volume_id &&
            file_tbl[i] == c.file_id) begin
          hit_at = i;
        end
        if (free_at < 0 && count_tbl[i] == '0 && !mount_tbl[i]) begin
          free_at = i;
        end
      end
      if (hit_at >= 0) begin
        s     = hit_at;
        r.hit = 1'b1;
        if (count_tbl[s] == COUNT_MAX) begin
          r.status = rict_pkg::STAT_OVERFLOW;
        end else begin
          count_tbl[s] = count_tbl[s] + 1'b1;
        end
      end else if (free_at >= 0) begin
        s               = free_at;
        occupied_tbl[s] = 1'b1;
        vol_tbl[s]      = c.volume_id;
        file_tbl[s]     = c.file_id;
        count_tbl[s]    = 16'd1;
        valid_tbl[s]    = 1'b0;
      end else begin
        r.status = rict_pkg::STAT_FULL;
        return r;
      end
    end else if (c.operation > rict_pkg::OP_UNMOUNT) begin
      return r;
    end else if (s >= ENTRIES) begin
      r.result_slot = c.slot;
      r.status      = rict_pkg::STAT_NOT_VALID;
      return r;
    end else begin
      case (c.operation)
        rict_pkg::OP_PIN: begin
          if (count_tbl[s] == '0) begin
            r.status = rict_pkg::STAT_RELEASED;
          end else if (count_tbl[s] == COUNT_MAX) begin
            r.status = rict_pkg::STAT_OVERFLOW;
          end else begin
            count_tbl[s] = count_tbl[s] + 1'b1;
          end
        end
        rict_pkg::OP_RELEASE: begin
          if (count_tbl[s] == '0) begin
            r.status = rict_pkg::STAT_RELEASED;
          end else begin
            count_tbl[s] = count_tbl[s] - 1'b1;
            freed        = (count_tbl[s] == '0);
          end
        end
        rict_pkg::OP_MARK_VALID: begin
          if (count_tbl[s] == '0) begin
            r.status = rict_pkg::STAT_RELEASED;
          end else begin
            valid_tbl[s] = 1'b1;
          end
        end
        rict_pkg::OP_MOUNT: begin
          if (!c.is_directory) begin
            r.status = rict_pkg::STAT_NOT_DIR;
          end else if (!valid_tbl[s]) begin
            r.status = rict_pkg::STAT_NOT_VALID;
          end else begin
            mount_tbl[s] = 1'b1;
          end
        end
        default: begin
          if (!c.is_directory) begin
            r.status = rict_pkg::STAT_NOT_DIR;
          end else if (!valid_tbl[s]) begin
            r.status = rict_pkg::STAT_NOT_VALID;
          end else if (!mount_tbl[s]) begin
            r.status = rict_pkg::STAT_NOT_MOUNTED;
          end else begin
            mount_tbl[s] = 1'b0;
          end
        end
      endcase
    end
    r.result_slot = s[5:0];
    r.count_after = count_tbl[s];
    r.became_free = freed;
    r.mounted     = mount_tbl[s];
    r.entry_valid = valid_tbl[s];
    return r;
  endfunction

  function automatic logic take_break();
    if (cycle_no >= 20000 && cycle_no < 32000) begin
      return 1'b0;
    end
    return $urandom_range(0, 99) < 9;
  endfunction

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
    mismatches++;
    if (mismatches <= 100) begin
      $display("mismatch in %s at cycle %0d: got %0h, expected %0h",
               field, cycle_no, got, want);
    end
  endtask

  task automatic add_cmd(logic [2:0] op, logic [15:0] vol, logic [31:0] fid,
                         logic [5:0] slot, logic dir, logic sync = 1'b0);
    table_cmd_t c;
    c.operation       = op;
    c.volume_id       = vol;
    c.file_id         = fid;
    c.slot            = slot;
    c.is_directory    = dir;
    c.hold_until_idle = sync;
    pending_cmds.push_back(c);
  endtask

  function automatic logic [2:0] pick_op(seg_t seg);
    int unsigned p;
    p = $urandom_range(0, 99);
    case (seg)
      SEG_FILL: begin
        if (p < 85) return rict_pkg::OP_ACQUIRE;
        if (p < 90) return rict_pkg::OP_PIN;
        if (p < 95) return rict_pkg::OP_MARK_VALID;
        return rict_pkg::OP_MOUNT;
      end
      SEG_DRAIN: begin
        if (p < 55) return rict_pkg::OP_RELEASE;
        if (p < 70) return rict_pkg::OP_UNMOUNT;
        if (p < 75) return rict_pkg::OP_MARK_VALID;
        if (p < 80) return rict_pkg::OP_PIN;
        if (p < 95) return rict_pkg::OP_ACQUIRE;
        return (p < 97) ? OP_RESERVED_LO : OP_RESERVED_HI;
      end
      default: begin
        if (p < 30) return rict_pkg::OP_ACQUIRE;
        if (p < 44) return rict_pkg::OP_PIN;
        if (p < 64) return rict_pkg::OP_RELEASE;
        if (p < 76) return rict_pkg::OP_MARK_VALID;
        if (p < 86) return rict_pkg::OP_MOUNT;
        if (p < 94) return rict_pkg::OP_UNMOUNT;
        return (p < 97) ? OP_RESERVED_LO : OP_RESERVED_HI;
      end
    endcase
  endfunction

  task automatic add_random_cmd(seg_t seg, logic sync);
    logic [2:0]  op;
    logic [15:0] vol;
    logic [31:0] fid;
    logic [5:0]  slot;
    logic        dir;
    logic [47:0] id;
    op   = pick_op(seg);
    vol  = 16'($urandom_range(0, 65535));
    fid  = $urandom;
    slot = ($urandom_range(0, 1) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 15));
    dir  = 1'($urandom_range(0, 1));
    if (op == rict_pkg::OP_MOUNT || op == rict_pkg::OP_UNMOUNT) begin
      dir = ($urandom_range(0, 99) < 80);
    end
    if (op == rict_pkg::OP_ACQUIRE) begin
      if (known_ids.size() != 0 &&
          $urandom_range(0, 99) < ((seg == SEG_FILL) ? 20 : 50)) begin
        id  = known_ids[$urandom_range(0, known_ids.size() - 1)];
        vol = id[47:32];
        fid = id[31:0];
      end else begin
        if ($urandom_range(0, 99) < 30) begin
          vol = 16'($urandom_range(0, 3));
          fid = 32'($urandom_range(0, 7));
        end
        known_ids.push_back({vol, fid});
        if (known_ids.size() > 40) begin
          void'(known_ids.pop_front());
        end
      end
    end
    add_cmd(op, vol, fid, slot, dir, sync);
  endtask

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
  end

  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_results.push_back(apply_to_table(on_offer));
        accepted_count <= accepted_count + 1;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_cmds.size() != 0 && !take_break() &&
            !(pending_cmds[0].hold_until_idle && expected_results.size() != 0)) begin
          on_offer = pending_cmds.pop_front();
          req_ch.operation    <= on_offer.operation;
          req_ch.volume_id    <= on_offer.volume_id;
          req_ch.file_id      <= on_offer.file_id;
          req_ch.slot         <= on_offer.slot;
          req_ch.is_directory <= on_offer.is_directory;
          req_ch.valid        <= 1'b1;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && accepted_count == 300) begin
      hold_left <= 600;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    table_rsp_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request waiting", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (rsp_ch.result_slot !== want.result_slot)
            report_mismatch("result_slot", rsp_ch.result_slot, want.result_slot);
          if (rsp_ch.hit !== want.hit)
            report_mismatch("hit", rsp_ch.hit, want.hit);
          if (rsp_ch.status !== want.status)
            report_mismatch("status", rsp_ch.status, want.status);
          if (rsp_ch.count_after !== want.count_after)
            report_mismatch("count_after", rsp_ch.count_after, want.count_after);
          if (rsp_ch.became_free !== want.became_free)
            report_mismatch("became_free", rsp_ch.became_free, want.became_free);
          if (rsp_ch.mounted !== want.mounted)
            report_mismatch("mounted", rsp_ch.mounted, want.mounted);
          if (rsp_ch.entry_valid !== want.entry_valid)
            report_mismatch("entry_valid", rsp_ch.entry_valid, want.entry_valid);
        end
      end
      rsp_ch.ready <= (hold_left == 0) && !take_break();
    end
  end

  initial begin
    int k;
    add_cmd(rict_pkg::OP_ACQUIRE, 16'h0000, 32'h0000_0000, 6'd0, 1'b0);
    add_cmd(rict_pkg::OP_ACQUIRE, 16'hFFFF, 32'hFFFF_FFFF, 6'd63, 1'b1);
    add_cmd(rict_pkg::OP_ACQUIRE, 16'h0000, 32'h0000_0000, 6'd0, 1'b0);
    add_cmd(rict_pkg::OP_PIN, 16'h0000, 32'h0000_0000, 6'd0, 1'b0);
    add_cmd(rict_pkg::OP_PIN, 16'h0000, 32'h0000_0000, 6'd63, 1'b0);
    add_cmd(rict_pkg::OP_RELEASE, 16'h0000, 32'h0000_0000, 6'd63, 1'b0);
    add_cmd(rict_pkg::OP_MARK_VALID, 16'h0000, 32'h0000_0000, 6'd63, 1'b0);
    add_cmd(rict_pkg::OP_MARK_VALID, 16'h0000, 32'h0000_0000, 6'd1, 1'b0);
    add_cmd(rict_pkg::OP_MOUNT, 16'h1234, 32'h0000_0001, 6'd1, 1'b0);
    add_cmd(rict_pkg::OP_MOUNT, 16'h1234, 32'h0000_0001, 6'd0, 1'b1);
    add_cmd(rict_pkg::OP_UNMOUNT, 16'h0000, 32'h0000_0000, 6'd1, 1'b1);
    add_cmd(rict_pkg::OP_MOUNT, 16'hABCD, 32'h1234_5678, 6'd1, 1'b1);
    add_cmd(rict_pkg::OP_MOUNT, 16'hFFFF, 32'hFFFF_FFFF, 6'd1, 1'b1);
    add_cmd(rict_pkg::OP_UNMOUNT, 16'h0000, 32'h0000_0000, 6'd0, 1'b0);
    add_cmd(rict_pkg::OP_UNMOUNT, 16'h0000, 32'h0000_0000, 6'd0, 1'b1);
    add_cmd(rict_pkg::OP_RELEASE, 16'h0000, 32'h0000_0000, 6'd1, 1'b0);
    add_cmd(rict_pkg::OP_ACQUIRE, 16'h0001, 32'h8000_0000, 6'd0, 1'b0);
    add_cmd(rict_pkg::OP_UNMOUNT, 16'h0000, 32'h0000_0000, 6'd1, 1'b1);
    add_cmd(OP_RESERVED_LO, 16'hFFFF, 32'hFFFF_FFFF, 6'd63, 1'b1);
    add_cmd(OP_RESERVED_HI, 16'hFFFF, 32'hFFFF_FFFF, 6'd63, 1'b1);
    add_cmd(rict_pkg::OP_RELEASE, 16'h0000, 32'h0000_0000, 6'd0, 1'b0);
    add_cmd(rict_pkg::OP_RELEASE, 16'h0000, 32'h0000_0000, 6'd0, 1'b0);
    add_cmd(rict_pkg::OP_RELEASE, 16'h0000, 32'h0000_0000, 6'd0, 1'b0);
    add_cmd(rict_pkg::OP_ACQUIRE, 16'hFFFF, 32'hFFFF_FFFF, 6'd0, 1'b0);

    for (k = 0; k < RANDOM_CMDS; k++) begin
      add_random_cmd(seg_t'((k / 110) % 3), (k == 0 || k == RANDOM_CMDS / 2));
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    while (pending_cmds.size() != 0 || req_ch.valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== refcounted_inode_cache_table.f =====
src/rict_pkg.sv
src/rict_req_if.sv
src/rict_rsp_if.sv
src/rict_cell.sv
src/refcounted_inode_cache_table.sv
verif/tb.sv
